@@ rtl/core/ppl_pkg.sv @@
// ----------------------------------------------------------------------------
// Partition prune lookup package
// Shared constants, codes and types of the partition prune lookup block.
// ----------------------------------------------------------------------------
package ppl_pkg;

   localparam int MAX_RANGES    = 256;
   localparam int KEY_WIDTH     = 32;
   localparam int IDX_WIDTH     = $clog2(MAX_RANGES);
   localparam int POS_WIDTH     = IDX_WIDTH + 2;
   localparam int RCOUNT_WIDTH  = IDX_WIDTH + 1;
   localparam int PCOUNT_WIDTH  = 16;
   localparam int OUT_IDX_WIDTH = 16;
   localparam int STRAT_WIDTH   = 3;
   localparam int OUTCOME_WIDTH = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_CNT_WIDTH = $clog2(KEY_WIDTH);
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // request kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // partitioning modes
   localparam logic MODE_HASH  = 1'b0;
   localparam logic MODE_RANGE = 1'b1;

   // comparison operators
   localparam logic [STRAT_WIDTH-1:0] STRAT_LT = 3'd0;
   localparam logic [STRAT_WIDTH-1:0] STRAT_LE = 3'd1;
   localparam logic [STRAT_WIDTH-1:0] STRAT_EQ = 3'd2;
   localparam logic [STRAT_WIDTH-1:0] STRAT_GE = 3'd3;
   localparam logic [STRAT_WIDTH-1:0] STRAT_GT = 3'd4;

   // result outcomes
   localparam logic [OUTCOME_WIDTH-1:0] OUT_SPAN = 2'd0;
   localparam logic [OUTCOME_WIDTH-1:0] OUT_ALL  = 2'd1;
   localparam logic [OUTCOME_WIDTH-1:0] OUT_NONE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PCOUNT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RCOUNT = 2'd2;

   typedef struct packed {
      logic                    mode;
      logic [PCOUNT_WIDTH-1:0] part_count;
      logic [RCOUNT_WIDTH-1:0] range_count;
   } ppl_cfg_type;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_HASH,
      KIND_RANGE,
      KIND_ALL
   } ppl_kind_type;

   typedef struct packed {
      ppl_kind_type           kind;
      logic [IDX_WIDTH-1:0]   index;
      logic [KEY_WIDTH-1:0]   lower;
      logic [KEY_WIDTH-1:0]   upper;
      logic [STRAT_WIDTH-1:0] strategy;
      logic [KEY_WIDTH-1:0]   key;
      logic [IDX_WIDTH-1:0]   last_entry;
   } ppl_item_type;

   typedef struct packed {
      logic [OUTCOME_WIDTH-1:0] outcome;
      logic [OUT_IDX_WIDTH-1:0] first_index;
      logic [OUT_IDX_WIDTH-1:0] last_index;
      logic                     found;
   } ppl_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_PROBE,
      ST_FINISH,
      ST_SEND
   } ppl_state_type;

endpackage

@@ rtl/core/ppl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ppl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ppl_front.sv @@
// ----------------------------------------------------------------------------
// Partition prune lookup front end
// Accepts requests, classifies them against the configuration and queues
// them for the back end.
// ----------------------------------------------------------------------------
module ppl_front (
   input  logic                           clock,
   input  logic                           reset,
   input  ppl_pkg::ppl_cfg_type           cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [ppl_pkg::IDX_WIDTH-1:0]  req_entry_index,
   input  logic [ppl_pkg::KEY_WIDTH-1:0]  req_entry_lower,
   input  logic [ppl_pkg::KEY_WIDTH-1:0]  req_entry_upper,
   input  logic [ppl_pkg::STRAT_WIDTH-1:0] req_strategy,
   input  logic [ppl_pkg::KEY_WIDTH-1:0]  req_key_value,
   output logic                           item_valid,
   input  logic                           item_ready,
   output ppl_pkg::ppl_item_type          item
);
   import ppl_pkg::*;

   ppl_item_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   ppl_item_type            new_item;
   logic [RCOUNT_WIDTH-1:0] n_clamp;
   logic                    push, pop;

   // classify
   always_comb begin
      n_clamp = (cfg.range_count > RCOUNT_WIDTH'(MAX_RANGES)) ?
                RCOUNT_WIDTH'(MAX_RANGES) : cfg.range_count;
      new_item.index      = req_entry_index;
      new_item.lower      = req_entry_lower;
      new_item.upper      = req_entry_upper;
      new_item.strategy   = req_strategy;
      new_item.key        = req_key_value;
      new_item.last_entry = IDX_WIDTH'(n_clamp - RCOUNT_WIDTH'(1));
      if (req_operation == OP_WRITE) begin
         new_item.kind = KIND_WRITE;
      end else if (cfg.mode == MODE_HASH) begin
         if (req_strategy == STRAT_EQ && cfg.part_count != '0) begin
            new_item.kind = KIND_HASH;
         end else begin
            new_item.kind = KIND_ALL;
         end
      end else if (req_strategy > STRAT_GT || n_clamp == '0) begin
         new_item.kind = KIND_ALL;
      end else begin
         new_item.kind = KIND_RANGE;
      end
   end

   assign req_ready  = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/core/ppl_back.sv @@
// ----------------------------------------------------------------------------
// Partition prune lookup back end
// Executes queued items: table writes, bit-serial hash remainder and
// bounds check plus bisection over the range table. Holds the result register.
// ----------------------------------------------------------------------------
module ppl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ppl_pkg::PCOUNT_WIDTH-1:0] part_count,
   input  logic                            item_valid,
   output logic                            item_ready,
   input  ppl_pkg::ppl_item_type           item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ppl_pkg::ppl_result_type         rsp
);
   import ppl_pkg::*;

   ppl_state_type             state_ff, state_in;
   ppl_item_type              item_ff, item_in;
   logic [KEY_WIDTH-1:0]      key_shift_ff, key_shift_in;
   logic [PCOUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0]  bit_cnt_ff, bit_cnt_in;
   logic signed [POS_WIDTH-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_WIDTH-1:0]      idx_ff, idx_in;
   logic                      found_ff, found_in;
   logic                      below_ff, below_in;
   ppl_result_type            res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ppl_result_type            rsp_ff, rsp_in;

   logic                      ram_wr_en, ram_rd_en;
   logic [IDX_WIDTH-1:0]      ram_rd_addr;
   logic [2*KEY_WIDTH-1:0]    ram_rd_data;

   logic signed [KEY_WIDTH-1:0] ent_lo, ent_hi, key_s;
   logic                      hit, key_lt_lo, above, out_free;
   logic [PCOUNT_WIDTH:0]     div_trial, div_diff;
   logic signed [POS_WIDTH-1:0] lo_next, hi_next, idx_s, last_s, first_s, span_last_s;
   logic [POS_WIDTH-1:0]      mid_sum;

   ppl_ram #(
      .WIDTH (2 * KEY_WIDTH),
      .DEPTH (MAX_RANGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item.index),
      .wr_data ({item.upper, item.lower}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ent_lo    = $signed(ram_rd_data[KEY_WIDTH-1:0]);
   assign ent_hi    = $signed(ram_rd_data[2*KEY_WIDTH-1:KEY_WIDTH]);
   assign key_s     = $signed(item_ff.key);
   assign hit       = (ent_lo <= key_s) && (key_s < ent_hi);
   assign key_lt_lo = (key_s < ent_lo);
   assign above     = (ent_hi < key_s);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign div_trial = {rem_ff, key_shift_ff[KEY_WIDTH-1]};
   assign div_diff  = div_trial - {1'b0, part_count};

   assign idx_s  = $signed({{(POS_WIDTH-IDX_WIDTH){1'b0}}, idx_ff});
   assign last_s = $signed({{(POS_WIDTH-IDX_WIDTH){1'b0}}, item_ff.last_entry});

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      key_shift_in = key_shift_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      below_in     = below_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      item_ready   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      lo_next      = lo_ff;
      hi_next      = hi_ff;
      mid_sum      = '0;
      first_s      = '0;
      span_last_s  = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               item_in      = item;
               key_shift_in = item.key;
               rem_in       = '0;
               bit_cnt_in   = DIV_CNT_WIDTH'(KEY_WIDTH - 1);
               found_in     = 1'b0;
               res_in       = '{outcome: OUT_ALL, first_index: '0, last_index: '0,
                                found: 1'b0};
               case (item.kind)
                  KIND_WRITE: ram_wr_en = 1'b1;
                  KIND_HASH:  state_in = ST_DIV;
                  KIND_RANGE: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_CHK_LO;
                  end
                  default:    state_in = ST_SEND;
               endcase
            end
         end

         ST_DIV: begin
            // restoring remainder, one key bit per cycle
            rem_in       = div_diff[PCOUNT_WIDTH] ? div_trial[PCOUNT_WIDTH-1:0]
                                                  : div_diff[PCOUNT_WIDTH-1:0];
            key_shift_in = key_shift_ff << 1;
            bit_cnt_in   = bit_cnt_ff - DIV_CNT_WIDTH'(1);
            if (bit_cnt_ff == '0) begin
               res_in.outcome     = OUT_SPAN;
               res_in.first_index = OUT_IDX_WIDTH'(rem_in);
               res_in.last_index  = OUT_IDX_WIDTH'(rem_in);
               state_in           = ST_SEND;
            end
         end

         ST_CHK_LO: begin
            below_in    = (ent_lo > key_s);
            ram_rd_en   = 1'b1;
            ram_rd_addr = item_ff.last_entry;
            state_in    = ST_CHK_HI;
         end

         ST_CHK_HI: begin
            if ((below_ff && (item_ff.strategy == STRAT_GE ||
                              item_ff.strategy == STRAT_GT)) ||
                (above && (item_ff.strategy == STRAT_LT ||
                           item_ff.strategy == STRAT_LE))) begin
               res_in.outcome = OUT_ALL;
               state_in       = ST_SEND;
            end else if (below_ff || above) begin
               res_in.outcome = OUT_NONE;
               state_in       = ST_SEND;
            end else begin
               lo_in       = '0;
               hi_in       = last_s;
               idx_in      = item_ff.last_entry >> 1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = item_ff.last_entry >> 1;
               state_in    = ST_PROBE;
            end
         end

         ST_PROBE: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else if (lo_ff == hi_ff) begin
               state_in = ST_FINISH;
            end else begin
               if (key_lt_lo) begin
                  hi_next = idx_s - POS_WIDTH'(1);
               end else begin
                  lo_next = idx_s + POS_WIDTH'(1);
               end
               lo_in = lo_next;
               hi_in = hi_next;
               if (lo_next <= hi_next) begin
                  mid_sum     = lo_next + hi_next;
                  idx_in      = mid_sum[IDX_WIDTH:1];
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = mid_sum[IDX_WIDTH:1];
               end else begin
                  // window emptied: keep the last probed entry
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            case (item_ff.strategy)
               STRAT_LT: begin
                  first_s     = '0;
                  span_last_s = (ent_lo == key_s) ? idx_s - POS_WIDTH'(1) : idx_s;
               end
               STRAT_LE: begin
                  first_s     = '0;
                  span_last_s = idx_s;
               end
               STRAT_EQ: begin
                  first_s     = found_ff ? idx_s : POS_WIDTH'(1);
                  span_last_s = found_ff ? idx_s : '0;
               end
               STRAT_GE: begin
                  first_s     = idx_s;
                  span_last_s = last_s;
               end
               default: begin
                  first_s     = (ent_hi == key_s) ? idx_s + POS_WIDTH'(1) : idx_s;
                  span_last_s = last_s;
               end
            endcase
            if (first_s > span_last_s) begin
               res_in.outcome = OUT_NONE;
            end else begin
               res_in.outcome     = OUT_SPAN;
               res_in.first_index = OUT_IDX_WIDTH'(first_s[IDX_WIDTH-1:0]);
               res_in.last_index  = OUT_IDX_WIDTH'(span_last_s[IDX_WIDTH-1:0]);
               res_in.found       = found_ff;
            end
            state_in = ST_SEND;
         end

         ST_SEND: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      key_shift_ff <= key_shift_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      below_ff     <= below_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ rtl/core/partition_prune_lookup.sv @@
// ----------------------------------------------------------------------------
// Partition prune lookup
// Range table of half-open key ranges with bisection search and hash mode
// remainder; answers each query with a partition span, all, or none.
// ----------------------------------------------------------------------------
// To rsp_tvalid: an all answer goes from idle straight to send; the bounds check reads the
//   first and last entries and may decide; else bisection probes (up to 9), then finish;
//   a hash query shifts every key bit; a table write lands when taken; stalls add to all.
// Throughput: one item at a time in the back end, behind a two-entry request queue.
// Reset: synchronous; mode resets to range, partition count to 1, range count to 0;
//   table contents are undefined until written.
module partition_prune_lookup (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] entry_index, [39:8] entry_lower, [71:40] entry_upper,
   // [74:72] strategy, [106:75] key_value, [111:107] zero
   input  logic [111:0] req_tdata,
   // [0] operation
   input  logic [0:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] first_index, [31:16] last_index, [32] found, [39:33] zero
   output logic [39:0]  rsp_tdata,
   // [1:0] outcome
   output logic [1:0]   rsp_tuser,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import ppl_pkg::*;

   ppl_cfg_type    cfg_ff, cfg_in;
   logic           item_valid, item_ready;
   ppl_item_type   item;
   ppl_result_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:   cfg_in.mode        = csr_data[0];
            CSR_PCOUNT: cfg_in.part_count  = csr_data[PCOUNT_WIDTH-1:0];
            CSR_RCOUNT: cfg_in.range_count = csr_data[RCOUNT_WIDTH-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_RANGE;
         cfg_ff.part_count  <= PCOUNT_WIDTH'(1);
         cfg_ff.range_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_operation   (req_tuser[0]),
      .req_entry_index (req_tdata[7:0]),
      .req_entry_lower (req_tdata[39:8]),
      .req_entry_upper (req_tdata[71:40]),
      .req_strategy    (req_tdata[74:72]),
      .req_key_value   (req_tdata[106:75]),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   ppl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .part_count (cfg_ff.part_count),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'b0, rsp.found, rsp.last_index, rsp.first_index};
   assign rsp_tuser = rsp.outcome;

`ifndef SYNTHESIS
   a_no_span_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.outcome != OUT_SPAN |->
         rsp.first_index == '0 && rsp.last_index == '0 && !rsp.found)
      else $error("non-span result carries span fields");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.outcome == OUT_SPAN |-> rsp.first_index <= rsp.last_index)
      else $error("span first index exceeds last index");

   a_hash_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.outcome == OUT_SPAN && cfg_ff.mode == MODE_HASH |->
         rsp.first_index == rsp.last_index && !rsp.found &&
         rsp.first_index < OUT_IDX_WIDTH'(cfg_ff.part_count))
      else $error("hash result is not a single partition below the count");

   a_found_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.found |-> rsp.outcome == OUT_SPAN)
      else $error("found flag set outside a span result");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition prune lookup testbench
// Drives table writes and prune queries through the request stream, tracks
// the range table and register state in a local predictor, and compares
// every response field by field against the predicted partition span.
// ----------------------------------------------------------------------------
module testbench;
   import ppl_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 400;
   localparam int PHASES       = 24;

   typedef struct {
      logic                    operation;
      logic [IDX_WIDTH-1:0]    index;
      logic signed [31:0]      lower;
      logic signed [31:0]      upper;
      logic [STRAT_WIDTH-1:0]  strategy;
      logic signed [31:0]      key;
   } prune_request_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic [0:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_data = '0;

   // predictor state
   logic signed [31:0]      tbl_lower [MAX_RANGES];
   logic signed [31:0]      tbl_upper [MAX_RANGES];
   logic                    cfg_mode = MODE_RANGE;
   logic [PCOUNT_WIDTH-1:0] cfg_pcount = 16'd1;
   logic [RCOUNT_WIDTH-1:0] cfg_rcount = '0;

   prune_request_type pending_requests [$];
   ppl_result_type expected_spans [$];
   int  requests_queued = 0;
   int  requests_accepted = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 18;
   int  recv_idle_pct = 66;
   int  hold_cycles = 0;
   bit  long_hold_go = 1'b0;
   logic req_fire = 1'b0;

   partition_prune_lookup DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Work out the span a query selects under the current table and registers.
   function automatic ppl_result_type prune_lookup(logic [STRAT_WIDTH-1:0] strat,
                                                   logic signed [31:0] key);
      ppl_result_type res;
      logic [31:0] key_bits;
      logic [31:0] rem;
      int n, lo, hi, pos, first, last;
      bit hit, below, above;
      res = '0;
      res.outcome = OUT_ALL;
      key_bits = key;
      if (cfg_mode == MODE_HASH) begin
         if (strat == STRAT_EQ && cfg_pcount != 0) begin
            rem = key_bits % {16'd0, cfg_pcount};
            res.outcome = OUT_SPAN;
            res.first_index = rem[15:0];
            res.last_index = rem[15:0];
         end
         return res;
      end
      n = (cfg_rcount > MAX_RANGES) ? MAX_RANGES : int'(cfg_rcount);
      if (strat > STRAT_GT || n == 0)
         return res;
      below = tbl_lower[0] > key;
      above = tbl_upper[n-1] < key;
      if ((below && (strat == STRAT_GE || strat == STRAT_GT)) ||
          (above && (strat == STRAT_LT || strat == STRAT_LE)))
         return res;
      if (below || above) begin
         res.outcome = OUT_NONE;
         return res;
      end
      lo = 0;
      hi = n - 1;
      pos = 0;
      hit = 1'b0;
      // stop on the entry holding the key, else on the last probe
      while (lo <= hi) begin
         pos = lo + (hi - lo) / 2;
         if (tbl_lower[pos] <= key && key < tbl_upper[pos]) begin
            hit = 1'b1;
            break;
         end
         if (lo == hi)
            break;
         if (key < tbl_lower[pos])
            hi = pos - 1;
         else
            lo = pos + 1;
      end
      first = 0;
      last = n - 1;
      case (strat)
         STRAT_LT: last = (tbl_lower[pos] == key) ? pos - 1 : pos;
         STRAT_LE: last = pos;
         STRAT_EQ: begin
            first = pos;
            last = hit ? pos : pos - 1;
         end
         STRAT_GE: first = pos;
         default:  first = (tbl_upper[pos] == key) ? pos + 1 : pos;
      endcase
      if (first > last) begin
         res.outcome = OUT_NONE;
         return res;
      end
      res.outcome = OUT_SPAN;
      res.first_index = first[15:0];
      res.last_index = last[15:0];
      res.found = hit;
      return res;
   endfunction

   task automatic send_request(logic op, logic [IDX_WIDTH-1:0] idx,
                               logic signed [31:0] lo, logic signed [31:0] up,
                               logic [STRAT_WIDTH-1:0] strat, logic signed [31:0] key);
      prune_request_type item;
      item.operation = op;
      item.index = idx;
      item.lower = lo;
      item.upper = up;
      item.strategy = strat;
      item.key = key;
      if (op == OP_WRITE) begin
         tbl_lower[idx] = lo;
         tbl_upper[idx] = up;
      end else begin
         expected_spans.push_back(prune_lookup(strat, key));
      end
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   task automatic write_register(logic [CSR_IDX_WIDTH-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODE:   cfg_mode = value[0];
         CSR_PCOUNT: cfg_pcount = value;
         CSR_RCOUNT: cfg_rcount = value[RCOUNT_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold until every request is in and every response is out, then let
   // a trailing table write retire.
   task automatic wait_idle;
      while (requests_accepted != requests_queued || expected_spans.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write a sorted table of n half-open ranges, with occasional gaps.
   task automatic load_table(int n);
      longint span, cur, width;
      logic signed [31:0] lo, up;
      span = 64'sd4294967296 / (2 * n + 2);
      cur = -64'sd2147483648 + ($urandom % span);
      for (int k = 0; k < n; k++) begin
         width = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 1 + ($urandom % span);
         lo = cur[31:0];
         up = cur[31:0] + width[31:0];
         send_request(OP_WRITE, k[IDX_WIDTH-1:0], lo, up, '0, '0);
         cur += width;
         if ($urandom_range(2) == 0)
            cur += $urandom % span;
      end
   endtask

   task automatic run_queries(int count);
      int choice, nn, k;
      logic signed [31:0] key;
      logic [STRAT_WIDTH-1:0] strat;
      nn = (cfg_rcount > MAX_RANGES) ? MAX_RANGES : int'(cfg_rcount);
      for (int q = 0; q < count; q++) begin
         choice = $urandom_range(99);
         if (choice < 8) begin
            // stray write, may break the ordering of the live table
            send_request(OP_WRITE, IDX_WIDTH'($urandom_range(0, MAX_RANGES - 1)),
                         $urandom, $urandom, STRAT_WIDTH'($urandom_range(0, 7)),
                         $urandom);
         end else begin
            strat = (choice < 14) ? STRAT_WIDTH'($urandom_range(5, 7))
                                  : STRAT_WIDTH'($urandom_range(STRAT_LT, STRAT_GT));
            case ($urandom_range(7))
               0: key = $urandom;
               1: key = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
               2: key = $urandom_range(0, 300);
               default: begin
                  if (nn == 0) begin
                     key = $urandom;
                  end else begin
                     k = $urandom_range(0, nn - 1);
                     key = ($urandom_range(1) ? tbl_lower[k] : tbl_upper[k]);
                     key = key + $urandom_range(0, 2) - 1;
                  end
               end
            endcase
            send_request(OP_QUERY, '0, '0, '0, strat, key);
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      prune_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req_tdata <= {5'd0, item.key, item.strategy, item.upper, item.lower, item.index};
            req_tuser <= item.operation;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure, with one long hold-off
   always @(negedge clock) begin
      if (long_hold_go && hold_cycles < LONG_HOLD) begin
         hold_cycles <= hold_cycles + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // response monitor and watchdog
   always @(posedge clock) begin
      ppl_result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         requests_accepted <= requests_accepted + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_spans.size() == 0) begin
            $error("response with no query outstanding: outcome %0d", rsp_tuser);
            error_count++;
         end else begin
            want = expected_spans.pop_front();
            if (rsp_tuser != want.outcome) begin
               $error("outcome: expected %0d, actual %0d", want.outcome, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] != want.first_index) begin
               $error("first_index: expected %0d, actual %0d", want.first_index,
                      rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[31:16] != want.last_index) begin
               $error("last_index: expected %0d, actual %0d", want.last_index,
                      rsp_tdata[31:16]);
               error_count++;
            end
            if (rsp_tdata[32] != want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tdata[32]);
               error_count++;
            end
         end
      end
   end

   initial begin
      int n;
      logic mode;
      logic [15:0] pcount;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // empty table answers all
      send_request(OP_QUERY, '0, '0, '0, STRAT_LT, 32'sd0);
      send_request(OP_WRITE, 8'd0, -32'sd5000, -32'sd1000, '0, '0);
      send_request(OP_WRITE, 8'd1, -32'sd1000, 32'sd0, '0, '0);
      send_request(OP_WRITE, 8'd2, 32'sd0, 32'sd1000, '0, '0);
      send_request(OP_WRITE, 8'd3, 32'sd2000, 32'sh7FFFFFFF, '0, '0);
      send_request(OP_WRITE, 8'd255, 32'sh80000000, 32'sh7FFFFFFF, 3'd7, 32'shFFFFFFFF);
      wait_idle();
      write_register(CSR_RCOUNT, 16'd4);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GE, 32'sh80000000);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LT, 32'sh80000000);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LT, -32'sd5000);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LE, 32'sh7FFFFFFF);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GT, 32'sh7FFFFFFF);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, 32'sd1500);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GE, 32'sd1500);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LT, 32'sd0);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GT, 32'sd999);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, -32'sd1);
      send_request(OP_QUERY, '0, '0, '0, 3'd5, 32'sd0);
      send_request(OP_QUERY, '0, '0, '0, 3'd6, 32'sd0);
      send_request(OP_QUERY, '0, '0, '0, 3'd7, 32'sd0);
      wait_idle();
      // key above the last upper bound
      write_register(CSR_RCOUNT, 16'd3);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LE, 32'sd5000);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GT, 32'sd5000);
      wait_idle();
      // hash mode: zero divisor, widest divisor, non-equal operator
      write_register(CSR_MODE, {15'd0, MODE_HASH});
      write_register(CSR_PCOUNT, 16'd0);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, 32'sd12345);
      wait_idle();
      write_register(CSR_PCOUNT, 16'hFFFF);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, 32'shFFFFFFFF);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, 32'sh7FFFFFFF);
      send_request(OP_QUERY, '0, '0, '0, STRAT_LT, 32'sd7);
      wait_idle();

      // fill the whole table so that every entry has been written
      load_table(MAX_RANGES);
      wait_idle();
      write_register(CSR_MODE, {15'd0, MODE_RANGE});
      write_register(CSR_PCOUNT, 16'd1);
      write_register(CSR_RCOUNT, 16'd300);
      send_request(OP_QUERY, '0, '0, '0, STRAT_EQ, tbl_lower[MAX_RANGES-1]);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GE, tbl_upper[MAX_RANGES-1]);
      wait_idle();
      write_register(CSR_RCOUNT, 16'(MAX_RANGES));
      send_request(OP_QUERY, '0, '0, '0, STRAT_LE, tbl_lower[0]);
      send_request(OP_QUERY, '0, '0, '0, STRAT_GT, tbl_upper[128] - 1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < PHASES / 3) begin
            send_idle_pct = 18;
            recv_idle_pct = 66;
         end else if (phase < 2 * PHASES / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         mode = ($urandom_range(3) != 0) ? MODE_RANGE : MODE_HASH;
         case ($urandom_range(15))
            0:       n = 0;
            1:       n = 1;
            2:       n = MAX_RANGES;
            3, 4:    n = 2;
            default: n = $urandom_range(3, 40);
         endcase
         case ($urandom_range(4))
            0:       pcount = 16'd1;
            1:       pcount = 16'hFFFF;
            2:       pcount = 16'($urandom_range(2, 16));
            default: pcount = 16'($urandom_range(1, 65535));
         endcase
         if (mode == MODE_RANGE && n > 0 && $urandom_range(4) != 0)
            load_table(n);
         wait_idle();
         write_register(CSR_MODE, {15'd0, mode});
         write_register(CSR_PCOUNT, pcount);
         write_register(CSR_RCOUNT, n[15:0]);
         // stall the response side long enough to back up the request path
         if (phase == 4)
            long_hold_go = 1'b1;
         run_queries(38);
         wait_idle();
      end

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
